/* design/ssp_pkg.sv */
`default_nettype none

package ssp_pkg;

	// Port field widths
	localparam int ACTION_W  = 2;
	localparam int KEY_W     = 8;
	localparam int PAY_IN_W  = 32;
	localparam int STATUS_W  = 2;
	localparam int PAY_OUT_W = 32;
	localparam int SLOT_W    = 8;
	localparam int COUNT_W   = 9;

	// Parameter defaults
	localparam int MAX_KEYS_DEF     = 256;
	localparam int PAYLOAD_BITS_DEF = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ATTACH    = 2'd0,
		ACT_REMOVE    = 2'd1,
		ACT_GET       = 2'd2,
		ACT_DESTROYED = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_ABSENT  = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_PRESENT = 2'd3
	} status_t;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

endpackage

`default_nettype wire

/* design/ssp_ram.sv */
`default_nettype none

// Single-port synchronous RAM, one access per cycle, registered read data.
module ssp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read; read returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

/* design/sparse_set_packed_table.sv */
// Channel   Handshake                 Payload
// -------   -----------------------   ------------------------------------------------
// command   start / busy              action, entity_key, payload_in
// result    done (one-cycle strobe)   status, found, payload_out, slot_index, entry_count
//
// Each transaction runs through a key map read, a slot map check, then writeback.
// The sequence is set by the single-port maps: the slot read depends on the key read.
// The result shows in the cycle after writeback; a new command may be taken that cycle.
// After reset a clearing pass writes every key map entry, with busy high.
// Presence is checked against the entry count and the slot-to-key map, so stale
// map entries are never trusted. The receiver cannot stall; results are never held back.
`default_nettype none

module sparse_set_packed_table #(
	parameter int MAX_KEYS     = ssp_pkg::MAX_KEYS_DEF,
	parameter int PAYLOAD_BITS = ssp_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [ssp_pkg::ACTION_W-1:0]   action,
	input  wire logic [ssp_pkg::KEY_W-1:0]      entity_key,
	input  wire logic [ssp_pkg::PAY_IN_W-1:0]   payload_in,
	output logic                                done,
	output logic [ssp_pkg::STATUS_W-1:0]        status,
	output logic                                found,
	output logic [ssp_pkg::PAY_OUT_W-1:0]       payload_out,
	output logic [ssp_pkg::SLOT_W-1:0]          slot_index,
	output logic [ssp_pkg::COUNT_W-1:0]         entry_count
);
	import ssp_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int XW = AW + KEY_W;
	localparam logic [XW-1:0] MAX_KEY_X = XW'(MAX_KEYS);
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_KEYS);
	localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_KEYS - 1);

	state_t state_q;

	logic [ACTION_W-1:0]     act_q;
	logic [AW-1:0]           key_q;
	logic                    key_ok_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [AW-1:0]           slot_q;
	logic [AW-1:0]           moved_q;
	logic [PAYLOAD_BITS-1:0] last_pay_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           clr_q;

	// Memory ports
	logic [AW-1:0]           k2s_addr, s2k_addr, pay_addr;
	logic                    k2s_we, s2k_we, pay_we;
	logic [AW-1:0]           k2s_wdata, s2k_wdata, k2s_rdata, s2k_rdata;
	logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;

	// Incoming key, range checked against the table size
	logic [XW-1:0] key_x;
	logic [AW-1:0] key_idx;
	logic          key_ok;
	logic [AW-1:0] last_slot;
	logic [AW-1:0] count_slot;

	assign key_x      = XW'(entity_key);
	assign key_idx    = key_x[AW-1:0];
	assign key_ok     = key_x < MAX_KEY_X;
	assign last_slot  = AW'(count_q - 1'b1);
	assign count_slot = AW'(count_q);
	assign busy       = (state_q != ST_IDLE);

	// Writeback decision
	logic          present, full;
	logic          do_attach, do_remove, do_move;
	status_t       stat_d;
	logic [AW-1:0] sidx_d;
	logic [CW-1:0] count_d;

	always_comb begin
		present   = key_ok_q && (CW'(slot_q) < count_q) && (s2k_rdata == key_q);
		full      = (count_q == FULL_CNT);
		do_attach = 1'b0;
		do_remove = 1'b0;
		stat_d    = STAT_OK;
		sidx_d    = '0;
		case (action_t'(act_q))
			ACT_ATTACH: begin
				if (present) begin
					stat_d = STAT_PRESENT;
					sidx_d = slot_q;
				end else if (!key_ok_q) begin
					stat_d = STAT_ABSENT;
				end else if (full) begin
					stat_d = STAT_FULL;
				end else begin
					do_attach = 1'b1;
					sidx_d    = count_slot;
				end
			end
			ACT_REMOVE, ACT_DESTROYED: begin
				if (present) begin
					do_remove = 1'b1;
					sidx_d    = slot_q;
				end else if (act_q == ACT_REMOVE) begin
					stat_d = STAT_ABSENT;
				end
			end
			ACT_GET: begin
				if (present) begin
					sidx_d = slot_q;
				end else begin
					stat_d = STAT_ABSENT;
				end
			end
			default: begin
				stat_d = STAT_OK;
			end
		endcase
		do_move = do_remove && (slot_q != last_slot);
		if (do_attach) begin
			count_d = count_q + 1'b1;
		end else if (do_remove) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	// Memory address and write muxing per phase
	always_comb begin
		k2s_addr  = key_idx;
		s2k_addr  = last_slot;
		pay_addr  = last_slot;
		k2s_we    = 1'b0;
		s2k_we    = 1'b0;
		pay_we    = 1'b0;
		k2s_wdata = count_slot;
		s2k_wdata = key_q;
		pay_wdata = pay_q;
		case (state_q)
			ST_CLEAR: begin
				k2s_addr  = clr_q;
				k2s_we    = 1'b1;
				k2s_wdata = '0;
			end
			ST_LOOK: begin
				s2k_addr = k2s_rdata;
				pay_addr = k2s_rdata;
			end
			ST_CHECK: begin
				if (do_attach) begin
					k2s_addr = key_q;
					s2k_addr = count_slot;
					pay_addr = count_slot;
					k2s_we   = 1'b1;
					s2k_we   = 1'b1;
					pay_we   = 1'b1;
				end else if (do_move) begin
					k2s_addr  = moved_q;
					s2k_addr  = slot_q;
					pay_addr  = slot_q;
					k2s_we    = 1'b1;
					s2k_we    = 1'b1;
					pay_we    = 1'b1;
					k2s_wdata = slot_q;
					s2k_wdata = moved_q;
					pay_wdata = last_pay_q;
				end
			end
			default: begin
				k2s_addr = key_idx;
			end
		endcase
	end

	ssp_ram #(.DEPTH(MAX_KEYS), .WIDTH(AW)) u_key_to_slot (
		.clk   (clk),
		.addr  (k2s_addr),
		.we    (k2s_we),
		.wdata (k2s_wdata),
		.rdata (k2s_rdata)
	);

	ssp_ram #(.DEPTH(MAX_KEYS), .WIDTH(AW)) u_slot_to_key (
		.clk   (clk),
		.addr  (s2k_addr),
		.we    (s2k_we),
		.wdata (s2k_wdata),
		.rdata (s2k_rdata)
	);

	ssp_ram #(.DEPTH(MAX_KEYS), .WIDTH(PAYLOAD_BITS)) u_payload (
		.clk   (clk),
		.addr  (pay_addr),
		.we    (pay_we),
		.wdata (pay_wdata),
		.rdata (pay_rdata)
	);

	// Sequencer, clearing pass, entry count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= (state_q == ST_CHECK);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= ST_IDLE;
					count_q <= count_d;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Transaction capture and lookup data
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			act_q    <= action;
			key_q    <= key_idx;
			key_ok_q <= key_ok;
			pay_q    <= PAYLOAD_BITS'(payload_in);
		end
		if (state_q == ST_LOOK) begin
			slot_q     <= k2s_rdata;
			moved_q    <= s2k_rdata;
			last_pay_q <= pay_rdata;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			status      <= stat_d;
			found       <= present;
			payload_out <= (act_q == ACT_GET && present) ? PAY_OUT_W'(pay_rdata) : '0;
			slot_index  <= SLOT_W'(sidx_d);
			entry_count <= COUNT_W'(count_d);
		end
	end

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_done_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |=> done)
		else $error("writeback not followed by result strobe");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond table size");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CHECK) |=> $stable(count_q))
		else $error("entry count changed outside writeback");

endmodule

`default_nettype wire
